/* rtl/core/ofvd_pkg.sv */
// Shared types and constants for the face vertex dedup block.
`timescale 1ns / 1ps
package ofvd_pkg;

    localparam int OP_W    = 3;
    localparam int RAW_W   = 22;
    localparam int CNT_W   = 21;
    localparam int SLOT_W  = 20;
    localparam int KEY_W   = 3 * SLOT_W;
    localparam int VIDX_W  = 12;
    localparam int STAT_W  = 2;
    localparam int EPOCH_W = 4;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_TABLE_SLOTS  = 8192;
    localparam int DEF_INDEX_BITS   = 20;

    // Hash product kept modulo 2^HASH_W, split into 24-bit low and 25-bit high parts.
    localparam int HASH_W     = 49;
    localparam int HASH_SPLIT = 24;
    localparam int HASH_SHIFT = 32;
    localparam logic [23:0] HASH_CL = 24'h4A7C15;
    localparam logic [24:0] HASH_CH = 25'h179B97F;

    typedef enum logic [OP_W-1:0] {
        OP_POS   = 3'd0,
        OP_UV    = 3'd1,
        OP_NORM  = 3'd2,
        OP_FACE  = 3'd3,
        OP_GROUP = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              is_group;
        logic              ok;
        logic [SLOT_W-1:0] ps;
        logic [SLOT_W-1:0] us;
        logic [SLOT_W-1:0] ns;
        logic              uvp;
        logic              nop;
    } cmd_t;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic              is_new;
        logic [SLOT_W-1:0] ps;
        logic [SLOT_W-1:0] us;
        logic [SLOT_W-1:0] ns;
        logic              uvp;
        logic              nop;
        status_t           status;
    } res_t;

endpackage

/* rtl/core/ofvd_fifo.sv */
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps
module ofvd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= din;
        end
    end

endmodule

/* rtl/core/ofvd_front.sv */
// Front: keeps the declaration counts, resolves and range-checks face indices.
`timescale 1ns / 1ps
module ofvd_front #(
    parameter int INDEX_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ofvd_pkg::OP_W-1:0]           operation,
    input  logic signed [ofvd_pkg::RAW_W-1:0]   raw_pos_index,
    input  logic signed [ofvd_pkg::RAW_W-1:0]   raw_uv_index,
    input  logic signed [ofvd_pkg::RAW_W-1:0]   raw_norm_index,
    input  logic                                init_busy,
    input  logic                                q_full,
    output logic                                q_push,
    output ofvd_pkg::cmd_t                      q_data
);
    import ofvd_pkg::*;

    localparam int RW = RAW_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [CNT_W-1:0] pos_cnt_reg, pos_cnt_next;
    logic [CNT_W-1:0] uv_cnt_reg, uv_cnt_next;
    logic [CNT_W-1:0] norm_cnt_reg, norm_cnt_next;
    logic             acc, uvp, nop;
    logic [RW-1:0]    p, u, n;
    logic             p_ok, u_ok, n_ok;

    function automatic logic [RW-1:0] resolve(input logic [RAW_W-1:0] raw,
                                              input logic [CNT_W-1:0] cnt);
        logic [RW-1:0] r;
        logic [RW-1:0] c;
        r = {raw[RAW_W-1], raw};
        c = {2'b00, cnt};
        if (raw == '0)
        begin
            return '0;
        end
        else if (raw[RAW_W-1])
        begin
            return c + r;
        end
        return r - RW'(1);
    endfunction

    function automatic logic in_range(input logic [RW-1:0] v, input logic [CNT_W-1:0] cnt);
        logic [RAW_W-1:0] mag;
        mag = v[RAW_W-1:0];
        return !v[RW-1] && (mag < {1'b0, cnt}) && ((mag >> INDEX_BITS) == '0);
    endfunction

    assign full = q_full || init_busy;
    assign acc  = push && !full;
    assign uvp  = (uv_cnt_reg != '0);
    assign nop  = (norm_cnt_reg != '0);
    assign p    = resolve(raw_pos_index, pos_cnt_reg);
    assign u    = uvp ? resolve(raw_uv_index, uv_cnt_reg) : '0;
    assign n    = nop ? resolve(raw_norm_index, norm_cnt_reg) : '0;
    assign p_ok = in_range(p, pos_cnt_reg);
    assign u_ok = !uvp || in_range(u, uv_cnt_reg);
    assign n_ok = !nop || in_range(n, norm_cnt_reg);

    always_comb
    begin
        pos_cnt_next     = pos_cnt_reg;
        uv_cnt_next      = uv_cnt_reg;
        norm_cnt_next    = norm_cnt_reg;
        q_push           = 1'b0;
        q_data.is_group  = 1'b0;
        q_data.ok        = p_ok && u_ok && n_ok;
        q_data.ps        = p[SLOT_W-1:0];
        q_data.us        = u[SLOT_W-1:0];
        q_data.ns        = n[SLOT_W-1:0];
        q_data.uvp       = uvp;
        q_data.nop       = nop;
        if (acc)
        begin
            case (op_t'(operation))
                OP_POS:
                begin
                    if (pos_cnt_reg != CNT_MAX)
                    begin
                        pos_cnt_next = pos_cnt_reg + 1'b1;
                    end
                end
                OP_UV:
                begin
                    if (uv_cnt_reg != CNT_MAX)
                    begin
                        uv_cnt_next = uv_cnt_reg + 1'b1;
                    end
                end
                OP_NORM:
                begin
                    if (norm_cnt_reg != CNT_MAX)
                    begin
                        norm_cnt_next = norm_cnt_reg + 1'b1;
                    end
                end
                OP_FACE:
                begin
                    q_push = 1'b1;
                end
                OP_GROUP:
                begin
                    q_push          = 1'b1;
                    q_data.is_group = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cnt_reg  <= '0;
            uv_cnt_reg   <= '0;
            norm_cnt_reg <= '0;
        end
        else
        begin
            pos_cnt_reg  <= pos_cnt_next;
            uv_cnt_reg   <= uv_cnt_next;
            norm_cnt_reg <= norm_cnt_next;
        end
    end

endmodule

/* rtl/core/ofvd_back.sv */
// Back: hashes the key, probes the slot table, allocates vertices, resets per group.
`timescale 1ns / 1ps
module ofvd_back #(
    parameter int MAX_VERTICES = 4096,
    parameter int TABLE_SLOTS  = 8192
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  ofvd_pkg::cmd_t q_data,
    output logic           q_pop,
    input  logic           o_full,
    output logic           o_push,
    output ofvd_pkg::res_t o_data,
    output logic           init_busy
);
    import ofvd_pkg::*;

    localparam int SB = $clog2(TABLE_SLOTS);
    localparam int TW = $clog2(TABLE_SLOTS + 1);
    localparam int UW = $clog2(MAX_VERTICES + 1);
    localparam int EW = EPOCH_W + KEY_W + VIDX_W;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_H0   = 9'b000000100,
        S_H1   = 9'b000001000,
        S_H2   = 9'b000010000,
        S_RD   = 9'b000100000,
        S_CHK  = 9'b001000000,
        S_EMIT = 9'b010000000,
        S_GCLR = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    res_t               res_reg, res_next;
    logic [SB-1:0]      slot_reg, slot_next;
    logic [SB-1:0]      clr_reg, clr_next;
    logic [TW-1:0]      tries_reg, tries_next;
    logic [HASH_W-1:0]  acc_reg, acc_next;
    logic [UW-1:0]      uniq_reg, uniq_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;

    logic [EW-1:0]      mem [TABLE_SLOTS];
    logic [EW-1:0]      rd_q;
    logic               mem_we;
    logic [SB-1:0]      mem_waddr;
    logic [EW-1:0]      mem_wdata;

    logic [KEY_W-1:0]   key;
    logic [24:0]        mul_a, mul_b;
    logic [49:0]        prod;
    logic [HASH_W-1:0]  prod_sh, hsum;
    logic [EPOCH_W-1:0] rd_epoch;
    logic [KEY_W-1:0]   rd_key;
    logic [VIDX_W-1:0]  rd_vidx;

    assign key       = {cmd_reg.ns, cmd_reg.us, cmd_reg.ps};
    assign prod      = mul_a * mul_b;
    assign prod_sh   = {prod[HASH_W-HASH_SPLIT-1:0], {HASH_SPLIT{1'b0}}};
    assign hsum      = acc_reg + prod_sh + {key[HASH_SPLIT], {(HASH_W-1){1'b0}}};
    assign rd_epoch  = rd_q[EW-1 -: EPOCH_W];
    assign rd_key    = rd_q[VIDX_W +: KEY_W];
    assign rd_vidx   = rd_q[VIDX_W-1:0];
    assign init_busy = (state_reg == S_INIT);
    assign o_data    = res_reg;

    always_comb
    begin
        mul_a = {1'b0, key[HASH_SPLIT-1:0]};
        mul_b = {1'b0, HASH_CL};
        case (state_reg)
            S_H1:
            begin
                mul_b = HASH_CH;
            end
            S_H2:
            begin
                mul_a = key[HASH_SPLIT +: 25];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        slot_next  = slot_reg;
        clr_next   = clr_reg;
        tries_next = tries_reg;
        acc_next   = acc_reg;
        uniq_next  = uniq_reg;
        epoch_next = epoch_reg;
        q_pop      = 1'b0;
        o_push     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = {epoch_reg, key, VIDX_W'(uniq_reg)};
        case (state_reg)
            S_INIT, S_GCLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SB'(TABLE_SLOTS - 1))
                begin
                    epoch_next = EPOCH_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = q_data;
                    res_next.vidx   = '0;
                    res_next.is_new = 1'b0;
                    res_next.ps     = q_data.ps;
                    res_next.us     = q_data.us;
                    res_next.ns     = q_data.ns;
                    res_next.uvp    = q_data.uvp;
                    res_next.nop    = q_data.nop;
                    res_next.status = STAT_OK;
                    if (q_data.is_group)
                    begin
                        uniq_next = '0;
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            clr_next   = '0;
                            state_next = S_GCLR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                    else if (!q_data.ok)
                    begin
                        res_next.status = STAT_RANGE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_H0;
                    end
                end
            end
            S_H0:
            begin
                acc_next   = prod[HASH_W-1:0];
                state_next = S_H1;
            end
            S_H1:
            begin
                acc_next   = acc_reg + prod_sh;
                state_next = S_H2;
            end
            S_H2:
            begin
                slot_next  = hsum[HASH_SHIFT +: SB];
                tries_next = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                tries_next = tries_reg + 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_EMIT;
                if (rd_epoch != epoch_reg)
                begin
                    if (uniq_reg >= UW'(MAX_VERTICES))
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        res_next.vidx   = VIDX_W'(uniq_reg);
                        res_next.is_new = 1'b1;
                        uniq_next       = uniq_reg + 1'b1;
                    end
                end
                else if (rd_key == key)
                begin
                    res_next.vidx = rd_vidx;
                end
                else if (tries_reg == TW'(TABLE_SLOTS))
                begin
                    res_next.status = STAT_FULL;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                if (!o_full)
                begin
                    o_push     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
            uniq_reg  <= '0;
            epoch_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            uniq_reg  <= uniq_next;
            epoch_reg <= epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        slot_reg  <= slot_next;
        tries_reg <= tries_next;
        acc_reg   <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[slot_reg];
    end

    a_uniq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        uniq_reg <= UW'(MAX_VERTICES))
        else $error("vertex count above limit");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_INIT || state_reg == S_GCLR || state_reg == S_CHK))
        else $error("table write outside init, clear or check");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && !q_empty))
        else $error("command pop outside idle");

    a_new_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && mem_we) |=> (uniq_reg == $past(uniq_reg) + 1'b1))
        else $error("allocation did not bump vertex count");

endmodule

/* rtl/core/obj_face_vertex_dedup.sv */
// Top level of the face vertex dedup block: front, command queue, back, result queue.
//
//  channel   | handshake      | fields
//  ----------+----------------+------------------------------------------------------
//  input     | push / full    | operation, raw_pos_index, raw_uv_index, raw_norm_index
//  result    | pop / empty    | vertex_index, is_new, pos_slot, uv_slot, norm_slot,
//            |                | uv_present, norm_present, status
//
// Declarations update the counts in the front. In the back a face item passes a
// three-step hash multiply, then a read and a compare per probed slot. A group
// break bumps the 4-bit epoch; when the epoch wraps the slot table is swept.
// After reset full stays high while the slot table is cleared. A four-deep
// command queue and a two-deep result queue let the front and the back stall
// independently.
`timescale 1ns / 1ps
module obj_face_vertex_dedup #(
    parameter int MAX_VERTICES = ofvd_pkg::DEF_MAX_VERTICES,
    parameter int TABLE_SLOTS  = ofvd_pkg::DEF_TABLE_SLOTS,
    parameter int INDEX_BITS   = ofvd_pkg::DEF_INDEX_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [ofvd_pkg::OP_W-1:0]          operation,
    input  logic signed [ofvd_pkg::RAW_W-1:0]  raw_pos_index,
    input  logic signed [ofvd_pkg::RAW_W-1:0]  raw_uv_index,
    input  logic signed [ofvd_pkg::RAW_W-1:0]  raw_norm_index,
    input  logic                               pop,
    output logic                               empty,
    output logic [ofvd_pkg::VIDX_W-1:0]        vertex_index,
    output logic                               is_new,
    output logic [ofvd_pkg::SLOT_W-1:0]        pos_slot,
    output logic [ofvd_pkg::SLOT_W-1:0]        uv_slot,
    output logic [ofvd_pkg::SLOT_W-1:0]        norm_slot,
    output logic                               uv_present,
    output logic                               norm_present,
    output logic [ofvd_pkg::STAT_W-1:0]        status
);
    import ofvd_pkg::*;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    logic init_busy;
    logic fq_push, fq_full, fq_pop, fq_empty;
    cmd_t fq_din, fq_dout;
    logic rq_push, rq_full;
    res_t rq_din, rq_dout;

    ofvd_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .raw_pos_index  (raw_pos_index),
        .raw_uv_index   (raw_uv_index),
        .raw_norm_index (raw_norm_index),
        .init_busy      (init_busy),
        .q_full         (fq_full),
        .q_push         (fq_push),
        .q_data         (fq_din)
    );

    ofvd_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_din),
        .full  (fq_full),
        .pop   (fq_pop),
        .dout  (fq_dout),
        .empty (fq_empty)
    );

    ofvd_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .TABLE_SLOTS  (TABLE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (fq_empty),
        .q_data    (fq_dout),
        .q_pop     (fq_pop),
        .o_full    (rq_full),
        .o_push    (rq_push),
        .o_data    (rq_din),
        .init_busy (init_busy)
    );

    ofvd_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign vertex_index = rq_dout.vidx;
    assign is_new       = rq_dout.is_new;
    assign pos_slot     = rq_dout.ps;
    assign uv_slot      = rq_dout.us;
    assign norm_slot    = rq_dout.ns;
    assign uv_present   = rq_dout.uvp;
    assign norm_present = rq_dout.nop;
    assign status       = rq_dout.status;

endmodule
